[hdl/w3sw_pkg.sv]
// Shared constants, register codes and the small remainder table for the
// WENO3 smoothness and weight block. No dependencies.
`default_nettype none

package w3sw_pkg;

    localparam int BETA_W     = 38;
    localparam int LIN_W      = 17;
    localparam int EPS_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [LIN_W-1:0] LEFT_WEIGHT_RST  = LIN_W'(36409);
    localparam logic [LIN_W-1:0] RIGHT_WEIGHT_RST = LIN_W'(29127);
    localparam logic [EPS_W-1:0] EPSILON_RST      = EPS_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_WEIGHT  = 2'd0,
        CFG_RIGHT_WEIGHT = 2'd1,
        CFG_EPSILON      = 2'd2
    } cfg_index_t;

    // floor(b*b/12) for a remainder b below twelve
    function automatic logic [3:0] sq_rem_div12(input logic [3:0] b);
        logic [3:0] r;
        unique case (b)
            4'd4:    r = 4'd1;
            4'd5:    r = 4'd2;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd4;
            4'd8:    r = 4'd5;
            4'd9:    r = 4'd6;
            4'd10:   r = 4'd8;
            4'd11:   r = 4'd10;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/w3sw_if.sv]
// Request channels of the WENO3 block: stencil in, result out.
// Depends on w3sw_pkg.
`default_nettype none

interface w3sw_stencil_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_m1;
    logic signed [SAMPLE_BITS-1:0] sample_0;
    logic signed [SAMPLE_BITS-1:0] sample_p1;
    logic signed [SAMPLE_BITS-1:0] sample_p2;

    modport source (output valid, sample_m1, sample_0, sample_p1, sample_p2, input ready);
    modport sink   (input valid, sample_m1, sample_0, sample_p1, sample_p2, output ready);
endinterface

interface w3sw_result_if #(parameter int WEIGHT_FRAC_BITS = 16);
    import w3sw_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [BETA_W-1:0]           beta_left;
    logic [BETA_W-1:0]           beta_right;
    logic [WEIGHT_FRAC_BITS:0]   weight_power_one;
    logic [WEIGHT_FRAC_BITS:0]   weight_power_two;
    logic                        zero_denominator;

    modport source (output valid, beta_left, beta_right, weight_power_one,
                    weight_power_two, zero_denominator, input ready);
    modport sink   (input valid, beta_left, beta_right, weight_power_one,
                    weight_power_two, zero_denominator, output ready);
endinterface

`default_nettype wire

[hdl/w3sw_beta.sv]
// Five-stage smoothness indicator pipeline: differences, squares, division
// of the second-difference square by twelve by reciprocal. Uses w3sw_pkg.
`default_nettype none

module w3sw_beta #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [SAMPLE_BITS-1:0] sample_m1,
    input  logic signed [SAMPLE_BITS-1:0] sample_0,
    input  logic signed [SAMPLE_BITS-1:0] sample_p1,
    input  logic signed [SAMPLE_BITS-1:0] sample_p2,
    output logic [2*SAMPLE_BITS+3:0]      beta_left,
    output logic [2*SAMPLE_BITS+3:0]      beta_right
);
    import w3sw_pkg::*;

    localparam int DC_W = SAMPLE_BITS;
    localparam int E_W  = SAMPLE_BITS + 1;
    localparam int Q_W  = E_W - 3;
    localparam int RP_W = E_W + Q_W;
    localparam int PQ_W = Q_W + E_W + 1;
    localparam int BW   = 2 * SAMPLE_BITS + 4;
    localparam logic [Q_W-1:0] RECIP = Q_W'((1 << E_W) / 12);

    logic signed [SAMPLE_BITS:0]   dl, dc, dr;
    logic signed [SAMPLE_BITS+1:0] el, er;
    logic [DC_W-1:0] adc_next;
    logic [E_W-1:0]  ae_next [2];

    logic [DC_W-1:0]   adc_reg;
    logic [E_W-1:0]    ae1_reg [2];
    logic [2*DC_W-1:0] dc2_s2_reg, dc2_s3_reg, dc2_s4_reg;
    logic [2*E_W-1:0]  e2_s2_reg [2];
    logic [2*E_W-1:0]  e2_s3_reg [2];
    logic [2*E_W-1:0]  e2_s4_reg [2];
    logic [E_W-1:0]    ae2_reg [2];
    logic [Q_W-1:0]    q0_reg [2];
    logic [E_W-1:0]    ae3_reg [2];
    logic [Q_W-1:0]    quo_reg [2];
    logic [3:0]        rem_reg [2];
    logic [PQ_W-1:0]   prod_reg [2];
    logic [3:0]        tail_reg [2];
    logic [BW-1:0]     beta_reg [2];

    logic [RP_W-1:0] rp [2];
    logic [E_W-1:0]  twelve [2];
    logic [E_W-1:0]  rem_full [2];
    logic            rem_ge [2];
    logic [Q_W-1:0]  quo_next [2];
    logic [3:0]      rem_next [2];
    logic [PQ_W-1:0] prod_next [2];
    logic [BW-1:0]   beta_next [2];

    always_comb
    begin
        dl = (SAMPLE_BITS+1)'(sample_0) - (SAMPLE_BITS+1)'(sample_m1);
        dc = (SAMPLE_BITS+1)'(sample_p1) - (SAMPLE_BITS+1)'(sample_0);
        dr = (SAMPLE_BITS+1)'(sample_p2) - (SAMPLE_BITS+1)'(sample_p1);
        el = (SAMPLE_BITS+2)'(dc) - (SAMPLE_BITS+2)'(dl);
        er = (SAMPLE_BITS+2)'(dr) - (SAMPLE_BITS+2)'(dc);
        adc_next   = dc[SAMPLE_BITS] ? DC_W'(-dc) : DC_W'(dc);
        ae_next[0] = el[SAMPLE_BITS+1] ? E_W'(-el) : E_W'(el);
        ae_next[1] = er[SAMPLE_BITS+1] ? E_W'(-er) : E_W'(er);
    end

    // |e| = 12*quo + rem, quotient estimate low by at most one
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rp[i]        = RP_W'(ae1_reg[i]) * RP_W'(RECIP);
            twelve[i]    = E_W'({q0_reg[i], 3'b000}) + E_W'({q0_reg[i], 2'b00});
            rem_full[i]  = ae2_reg[i] - twelve[i];
            rem_ge[i]    = rem_full[i] >= E_W'(12);
            quo_next[i]  = q0_reg[i] + Q_W'(rem_ge[i]);
            rem_next[i]  = rem_ge[i] ? 4'(rem_full[i] - E_W'(12)) : 4'(rem_full[i]);
            prod_next[i] = PQ_W'(quo_reg[i]) * (PQ_W'(ae3_reg[i]) + PQ_W'(rem_reg[i]));
            beta_next[i] = BW'(dc2_s4_reg) + BW'(e2_s4_reg[i]) + BW'(prod_reg[i])
                         + BW'(tail_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adc_reg    <= adc_next;
            dc2_s2_reg <= (2*DC_W)'(adc_reg) * (2*DC_W)'(adc_reg);
            dc2_s3_reg <= dc2_s2_reg;
            dc2_s4_reg <= dc2_s3_reg;
            for (int i = 0; i < 2; i++)
            begin
                ae1_reg[i]   <= ae_next[i];
                e2_s2_reg[i] <= (2*E_W)'(ae1_reg[i]) * (2*E_W)'(ae1_reg[i]);
                ae2_reg[i]   <= ae1_reg[i];
                q0_reg[i]    <= rp[i][RP_W-1:E_W];
                e2_s3_reg[i] <= e2_s2_reg[i];
                ae3_reg[i]   <= ae2_reg[i];
                quo_reg[i]   <= quo_next[i];
                rem_reg[i]   <= rem_next[i];
                e2_s4_reg[i] <= e2_s3_reg[i];
                prod_reg[i]  <= prod_next[i];
                tail_reg[i]  <= sq_rem_div12(rem_reg[i]);
                beta_reg[i]  <= beta_next[i];
            end
        end
    end

    assign beta_left  = beta_reg[0];
    assign beta_right = beta_reg[1];

endmodule

`default_nettype wire

[hdl/w3sw_mul.sv]
// Two-stage wide multiplier: 32x32 partial products, then a shifted sum.
// No dependencies.
`default_nettype none

module w3sw_mul #(
    parameter int A_W = 37,
    parameter int B_W = 17
) (
    input  logic               clk,
    input  logic               en,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);
    localparam int CA     = (A_W + 31) / 32;
    localparam int CB     = (B_W + 31) / 32;
    localparam int P_W    = A_W + B_W;
    localparam int FULL_W = 32 * (CA + CB);

    logic [32*CA-1:0]  a_ext;
    logic [32*CB-1:0]  b_ext;
    logic [63:0]       pp_reg [CA*CB];
    logic [FULL_W-1:0] sum;
    logic [P_W-1:0]    p_reg;

    assign a_ext = (32*CA)'(a);
    assign b_ext = (32*CB)'(b);

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < CA; i++)
            for (int j = 0; j < CB; j++)
                sum = sum + (FULL_W'(pp_reg[i*CB+j]) << (32 * (i + j)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < CA; i++)
                for (int j = 0; j < CB; j++)
                    pp_reg[i*CB+j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
            p_reg <= sum[P_W-1:0];
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[hdl/w3sw_div.sv]
// Pipelined restoring fraction divider, one quotient bit per stage.
// Expects num <= den. No dependencies.
`default_nettype none

module w3sw_div #(
    parameter int W     = 55,
    parameter int STEPS = 17
) (
    input  logic             clk,
    input  logic             en,
    input  logic [W-1:0]     num,
    input  logic [W-1:0]     den,
    output logic [STEPS-1:0] quo
);
    logic [W-1:0]     rem_reg  [STEPS];
    logic [W-1:0]     den_reg  [STEPS];
    logic [STEPS-1:0] quo_reg  [STEPS];
    logic [W-1:0]     rem_next [STEPS];
    logic [STEPS-1:0] quo_next [STEPS];
    logic [W:0]       shifted  [STEPS];
    logic             ge       [STEPS];

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            if (k == 0)
            begin
                shifted[k]  = {1'b0, num};
                ge[k]       = num >= den;
                rem_next[k] = ge[k] ? num - den : num;
                quo_next[k] = STEPS'(ge[k]);
            end
            else
            begin
                shifted[k]  = {rem_reg[k-1], 1'b0};
                ge[k]       = shifted[k] >= {1'b0, den_reg[k-1]};
                rem_next[k] = ge[k] ? W'(shifted[k] - {1'b0, den_reg[k-1]}) : W'(shifted[k]);
                quo_next[k] = {quo_reg[k-1][STEPS-2:0], ge[k]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den;
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            for (int k = 1; k < STEPS; k++)
                den_reg[k] <= den_reg[k-1];
        end
    end

    assign quo = quo_reg[STEPS-1];

endmodule

`default_nettype wire

[hdl/weno3_smoothness_and_weights.sv]
// Top level of the WENO3 smoothness indicator and nonlinear weight block.
// Depends on w3sw_pkg, w3sw_if, w3sw_beta, w3sw_mul and w3sw_div.
//
// channel   dir  request contents
// stencil   in   sample_m1, sample_0, sample_p1, sample_p2
// result    out  beta_left, beta_right, weight_power_one/two, zero_denominator
// wr_*      in   register write: index, data
//
// One request per cycle while results are taken; the divider resolves one
// quotient bit per stage.
// Reset clears the valid pipe and loads the register defaults.
// While a result waits untaken the whole pipe holds; nothing is lost.
`default_nettype none

module weno3_smoothness_and_weights #(
    parameter int SAMPLE_BITS      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [w3sw_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [w3sw_pkg::CFG_DATA_W-1:0]      wr_data,
    w3sw_stencil_if.sink                         stencil,
    w3sw_result_if.source                        result
);
    import w3sw_pkg::*;

    localparam int BW    = 2 * SAMPLE_BITS + 4;
    localparam int SL_W  = ((BW > EPS_W) ? BW : EPS_W) + 1;
    localparam int N1_W  = SL_W + LIN_W;
    localparam int D1_W  = N1_W + 1;
    localparam int SQ_W  = 2 * SL_W;
    localparam int N2_W  = SQ_W + LIN_W;
    localparam int D2_W  = N2_W + 1;
    localparam int STEPS = WEIGHT_FRAC_BITS + 1;
    localparam int LAT   = STEPS + 11;

    logic [LIN_W-1:0] left_weight_reg;
    logic [LIN_W-1:0] right_weight_reg;
    logic [EPS_W-1:0] epsilon_reg;

    logic           en;
    logic [LAT-1:0] vld_reg;

    logic [BW-1:0]   bl, br;
    logic [SL_W-1:0] sl_reg, sr_reg;
    logic [BW-1:0]   bl_dly_reg [LAT-5];
    logic [BW-1:0]   br_dly_reg [LAT-5];
    logic [N1_W-1:0] n1, m1;
    logic [N1_W-1:0] n1_dly_reg [2];
    logic [N1_W-1:0] m1_dly_reg [2];
    logic [SQ_W-1:0] sq_r, sq_l;
    logic [N2_W-1:0] n2, m2;
    logic [D1_W-1:0] d1_sum, d1_reg, n1_reg;
    logic [D2_W-1:0] d2_sum, d2_reg, n2_reg;
    logic            zero_reg;
    logic            zero_dly_reg [STEPS];
    logic [STEPS-1:0] q1, q2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_weight_reg  <= LEFT_WEIGHT_RST;
            right_weight_reg <= RIGHT_WEIGHT_RST;
            epsilon_reg      <= EPSILON_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_LEFT_WEIGHT:  left_weight_reg  <= wr_data[LIN_W-1:0];
                CFG_RIGHT_WEIGHT: right_weight_reg <= wr_data[LIN_W-1:0];
                CFG_EPSILON:      epsilon_reg      <= wr_data[EPS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign en            = !vld_reg[LAT-1] || result.ready;
    assign stencil.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], stencil.valid};
    end

    w3sw_beta #(.SAMPLE_BITS(SAMPLE_BITS)) u_beta (
        .clk        (clk),
        .en         (en),
        .sample_m1  (stencil.sample_m1),
        .sample_0   (stencil.sample_0),
        .sample_p1  (stencil.sample_p1),
        .sample_p2  (stencil.sample_p2),
        .beta_left  (bl),
        .beta_right (br)
    );

    w3sw_mul #(.A_W(SL_W), .B_W(LIN_W)) u_mul_n1 (
        .clk(clk), .en(en), .a(sr_reg), .b(left_weight_reg), .p(n1)
    );
    w3sw_mul #(.A_W(SL_W), .B_W(LIN_W)) u_mul_m1 (
        .clk(clk), .en(en), .a(sl_reg), .b(right_weight_reg), .p(m1)
    );
    w3sw_mul #(.A_W(SL_W), .B_W(SL_W)) u_mul_sqr (
        .clk(clk), .en(en), .a(sr_reg), .b(sr_reg), .p(sq_r)
    );
    w3sw_mul #(.A_W(SL_W), .B_W(SL_W)) u_mul_sql (
        .clk(clk), .en(en), .a(sl_reg), .b(sl_reg), .p(sq_l)
    );
    w3sw_mul #(.A_W(SQ_W), .B_W(LIN_W)) u_mul_n2 (
        .clk(clk), .en(en), .a(sq_r), .b(left_weight_reg), .p(n2)
    );
    w3sw_mul #(.A_W(SQ_W), .B_W(LIN_W)) u_mul_m2 (
        .clk(clk), .en(en), .a(sq_l), .b(right_weight_reg), .p(m2)
    );

    assign d1_sum = D1_W'(n1_dly_reg[1]) + D1_W'(m1_dly_reg[1]);
    assign d2_sum = D2_W'(n2) + D2_W'(m2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl_reg        <= SL_W'(epsilon_reg) + SL_W'(bl);
            sr_reg        <= SL_W'(epsilon_reg) + SL_W'(br);
            bl_dly_reg[0] <= bl;
            br_dly_reg[0] <= br;
            for (int k = 1; k < LAT - 5; k++)
            begin
                bl_dly_reg[k] <= bl_dly_reg[k-1];
                br_dly_reg[k] <= br_dly_reg[k-1];
            end
            n1_dly_reg[0] <= n1;
            n1_dly_reg[1] <= n1_dly_reg[0];
            m1_dly_reg[0] <= m1;
            m1_dly_reg[1] <= m1_dly_reg[0];
            n1_reg        <= D1_W'(n1_dly_reg[1]);
            d1_reg        <= d1_sum;
            n2_reg        <= D2_W'(n2);
            d2_reg        <= d2_sum;
            zero_reg      <= (d1_sum == '0) || (d2_sum == '0);
            zero_dly_reg[0] <= zero_reg;
            for (int k = 1; k < STEPS; k++)
                zero_dly_reg[k] <= zero_dly_reg[k-1];
        end
    end

    w3sw_div #(.W(D1_W), .STEPS(STEPS)) u_div1 (
        .clk(clk), .en(en), .num(n1_reg), .den(d1_reg), .quo(q1)
    );
    w3sw_div #(.W(D2_W), .STEPS(STEPS)) u_div2 (
        .clk(clk), .en(en), .num(n2_reg), .den(d2_reg), .quo(q2)
    );

    assign result.valid            = vld_reg[LAT-1];
    assign result.beta_left        = BETA_W'(bl_dly_reg[LAT-6]);
    assign result.beta_right       = BETA_W'(br_dly_reg[LAT-6]);
    assign result.zero_denominator = zero_dly_reg[STEPS-1];
    assign result.weight_power_one = zero_dly_reg[STEPS-1] ? '0 : q1;
    assign result.weight_power_two = zero_dly_reg[STEPS-1] ? '0 : q2;

endmodule

`default_nettype wire

[bench/weno3_smoothness_and_weights_tb.sv]
// Self-checking bench for weno3_smoothness_and_weights: drives stencil requests through
// random stalls and register settings; checks each result against a typed or predicted
// value. Depends on w3sw_pkg, w3sw_if and the block's RTL.
`timescale 1ns / 1ps

module weno3_smoothness_and_weights_tb;
    import w3sw_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [15:0] m1;
        logic signed [15:0] z0;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
    } stencil_t;

    typedef struct packed {
        logic [BETA_W-1:0] beta_l;
        logic [BETA_W-1:0] beta_r;
        logic [16:0]       w_one;
        logic [16:0]       w_two;
        logic              zero_den;
    } weights_t;

    typedef struct packed {
        stencil_t s;
        logic     typed;
        weights_t w;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    w3sw_stencil_if #(.SAMPLE_BITS(16)) st();
    w3sw_result_if #(.WEIGHT_FRAC_BITS(16)) res();

    weno3_smoothness_and_weights dut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .stencil(st), .result(res)
    );

    logic [LIN_W-1:0] cl_model = LEFT_WEIGHT_RST;
    logic [LIN_W-1:0] cr_model = RIGHT_WEIGHT_RST;
    logic [EPS_W-1:0] eps_model = EPSILON_RST;

    weights_t pending_weights[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_req = 1'b0;
    bit  no_idle = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned square_abs(input longint x);
        longint unsigned a;
        a = (x < 0) ? longint'(-x) : longint'(x);
        return a * a;
    endfunction

    function automatic weights_t predict_weights(input stencil_t s);
        longint dl, dc, dr;
        longint unsigned bl, br, sl, sr;
        logic [127:0] n1, d1, n2, d2;
        weights_t w;
        dl = longint'(s.z0) - longint'(s.m1);
        dc = longint'(s.p1) - longint'(s.z0);
        dr = longint'(s.p2) - longint'(s.p1);
        bl = square_abs(dc) + (13 * square_abs(dc - dl)) / 12;
        br = square_abs(dc) + (13 * square_abs(dr - dc)) / 12;
        sl = longint'(eps_model) + bl;
        sr = longint'(eps_model) + br;
        n1 = 128'(cl_model) * 128'(sr);
        d1 = n1 + 128'(cr_model) * 128'(sl);
        n2 = 128'(sr) * 128'(sr) * 128'(cl_model);
        d2 = n2 + 128'(sl) * 128'(sl) * 128'(cr_model);
        w.beta_l = bl[BETA_W-1:0];
        w.beta_r = br[BETA_W-1:0];
        w.zero_den = (d1 == 0) || (d2 == 0);
        w.w_one = w.zero_den ? 17'd0 : 17'((n1 << 16) / d1);
        w.w_two = w.zero_den ? 17'd0 : 17'((n2 << 16) / d2);
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic stencil_t random_stencil();
        stencil_t s;
        int kind, slope, curve;
        kind = $urandom_range(0, 9);
        s = stencil_t'({$urandom, $urandom});
        if (kind == 0)
        begin
            s.z0 = s.m1;
            s.p1 = s.m1;
            s.p2 = s.m1;
        end
        else if (kind <= 3)
        begin
            slope = $urandom_range(0, 400) - 200;
            curve = $urandom_range(0, 20) - 10;
            s.z0 = s.m1 + 16'(slope);
            s.p1 = s.z0 + 16'(slope + curve);
            s.p2 = s.p1 + 16'(slope + 2 * curve);
        end
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            CFG_LEFT_WEIGHT:  cl_model = val[LIN_W-1:0];
            CFG_RIGHT_WEIGHT: cr_model = val[LIN_W-1:0];
            CFG_EPSILON:      eps_model = val[EPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_stencil(input stencil_t s, input logic typed, input weights_t w);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            st.valid <= 1'b0;
        end
        @(negedge clk);
        st.valid <= 1'b1;
        st.sample_m1 <= s.m1;
        st.sample_0 <= s.z0;
        st.sample_p1 <= s.p1;
        st.sample_p2 <= s.p2;
        do
            @(posedge clk);
        while (!(st.valid && st.ready));
        pending_weights.push_back(typed ? w : predict_weights(s));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        st.valid <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_burst(input int n);
        for (int i = 0; i < n; i++)
            send_stencil(random_stencil(), 1'b0, '0);
    endtask

    // result side
    initial
    begin
        int stall;
        int hold;
        weights_t want, got;
        stall = 0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold = 200;
                while (hold > 0)
                begin
                    res.ready <= 1'b0;
                    @(negedge clk);
                    hold--;
                end
            end
            if (stall > 0)
            begin
                stall--;
                res.ready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                res.ready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                got = '{res.beta_left, res.beta_right, res.weight_power_one,
                        res.weight_power_two, res.zero_denominator};
                if (pending_weights.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = pending_weights.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((st.valid && st.ready) || (res.valid && res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        stencil_t s;
        st.valid = 1'b0;
        st.sample_m1 = '0;
        st.sample_0 = '0;
        st.sample_p1 = '0;
        st.sample_p2 = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // flat stencil at reset weights: betas zero, weights equal to cL
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
                         '{38'd0, 38'd0, 17'd36409, 17'd36409, 1'b0}});
        rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b1,
                         '{38'd0, 38'd0, 17'd36409, 17'd36409, 1'b0}});
        rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b1,
                         '{38'd0, 38'd0, 17'd36409, 17'd36409, 1'b0}});
        rows.push_back('{'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, '0});
        rows.push_back('{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '0});
        rows.push_back('{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b0, '0});
        rows.push_back('{'{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768}, 1'b0, '0});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767}, 1'b0, '0});
        rows.push_back('{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd1, 16'sd2, 16'sd3, 16'sd4}, 1'b0, '0});
        rows.push_back('{'{16'sd0, 16'sd1, 16'sd4, 16'sd9}, 1'b0, '0});
        rows.push_back('{'{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, -16'sd1}, 1'b0, '0});
        foreach (rows[i])
            send_stencil(rows[i].s, rows[i].typed, rows[i].w);
        random_burst(180);
        wait_drained();

        // long hold-off on the result side while stencils keep coming
        hold_req = 1'b1;
        random_burst(100);
        wait_drained();

        // no linear weight at all: every denominator vanishes
        write_reg(CFG_LEFT_WEIGHT, 32'd0);
        write_reg(CFG_RIGHT_WEIGHT, 32'd0);
        random_burst(60);
        wait_drained();

        // zero epsilon: flat stencils give a zero denominator
        write_reg(CFG_LEFT_WEIGHT, 32'd65536);
        write_reg(CFG_RIGHT_WEIGHT, 32'd65536);
        write_reg(CFG_EPSILON, 32'd0);
        for (int i = 0; i < 6; i++)
        begin
            s = random_stencil();
            s.z0 = s.m1;
            s.p1 = s.m1;
            s.p2 = s.m1;
            send_stencil(s, 1'b1, '{38'd0, 38'd0, 17'd0, 17'd0, 1'b1});
        end
        random_burst(200);
        wait_drained();

        // full-scale left weight and epsilon, zero right weight, unused index written
        write_reg(CFG_LEFT_WEIGHT, 32'hFFFF_FFFF);
        write_reg(CFG_RIGHT_WEIGHT, 32'd0);
        write_reg(CFG_EPSILON, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'h0000_1234);
        no_idle = 1'b1;
        random_burst(200);
        wait_drained();
        no_idle = 1'b0;

        write_reg(CFG_LEFT_WEIGHT, 32'd0);
        write_reg(CFG_RIGHT_WEIGHT, 32'h0001_FFFF);
        write_reg(CFG_EPSILON, 32'd1);
        random_burst(150);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_LEFT_WEIGHT, $urandom);
            write_reg(CFG_RIGHT_WEIGHT, $urandom);
            write_reg(CFG_EPSILON, (ph[0]) ? $urandom_range(0, 1000) : $urandom);
            random_burst(140);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[weno3_smoothness_and_weights.f]
hdl/w3sw_pkg.sv
hdl/w3sw_if.sv
hdl/w3sw_beta.sv
hdl/w3sw_mul.sv
hdl/w3sw_div.sv
hdl/weno3_smoothness_and_weights.sv
bench/weno3_smoothness_and_weights_tb.sv
